@@ sv/mds_pkg.sv @@
package mds_pkg;

   localparam int MAX_DIGITS_DEFAULT = 4;

   // Register indexes on the csr port
   localparam logic CSR_DIGIT_COUNT   = 1'b0;
   localparam logic CSR_INVERTED_MODE = 1'b1;

   // Reset values of the configuration registers
   localparam logic [2:0] DIGIT_COUNT_RESET = 3'd4;

   // Reciprocal multipliers for the decimal split of a 14-bit number
   localparam logic [12:0] TENTH_MUL      = 13'd6554;  // >> 16
   localparam logic [12:0] HUNDREDTH_MUL  = 13'd5243;  // >> 19
   localparam logic [13:0] THOUSANDTH_MUL = 14'd8389;  // >> 23

   typedef enum logic [1:0] {
      KIND_SET_RAW    = 2'd0,
      KIND_SET_NUMBER = 2'd1,
      KIND_READ       = 2'd2,
      KIND_SCAN       = 2'd3
   } kind_type;

   // Accepted beat plus its precomputed quotients
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  digit_index;
      logic [7:0]  segment_value;
      logic [13:0] number_value;
      logic [10:0] quot_ten;
      logic [7:0]  quot_hundred;
      logic [4:0]  quot_thousand;
   } item_type;

   typedef struct packed {
      logic [7:0] segment_port;
      logic [3:0] digit_enable;
      logic [7:0] read_value;
   } result_type;

   // bit0 = a .. bit6 = g, active high
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'h3F;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5B;
         4'd3:    pat = 8'h4F;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6D;
         4'd6:    pat = 8'h7D;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7F;
         4'd9:    pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

@@ sv/mds_decimal_split.sv @@
module mds_decimal_split (
   input  logic [13:0] number_value,
   output logic [10:0] quot_ten,
   output logic [7:0]  quot_hundred,
   output logic [4:0]  quot_thousand
);
   import mds_pkg::*;

   logic [26:0] prod_ten;
   logic [26:0] prod_hundred;
   logic [27:0] prod_thousand;

   // Exact floor quotients for every 14-bit input
   assign prod_ten      = 27'(number_value) * 27'(TENTH_MUL);
   assign prod_hundred  = 27'(number_value) * 27'(HUNDREDTH_MUL);
   assign prod_thousand = 28'(number_value) * 28'(THOUSANDTH_MUL);

   assign quot_ten      = prod_ten[26:16];
   assign quot_hundred  = prod_hundred[26:19];
   assign quot_thousand = prod_thousand[27:23];

endmodule

@@ sv/mds_display_state.sv @@
module mds_display_state #(
   parameter int MAX_DIGITS = mds_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [2:0]         csr_wdata,
   input  logic               fire,
   input  mds_pkg::item_type  item,
   output mds_pkg::result_type result
);
   import mds_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [2:0]       count_ff;
   logic             inv_ff;
   logic [7:0]       store_ff [MAX_DIGITS];
   logic [7:0]       store_in [MAX_DIGITS];
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [3:0]       pins_ff, pins_in;
   logic [7:0]       latch_ff, latch_in;

   logic [2:0]       active;
   logic [3:0]       digit [4];
   logic [10:0]      rem_ten;
   logic [7:0]       rem_hundred;
   logic [13:0]      rem_unit;
   logic [IDX_W-1:0] scan_pos;
   logic [2:0]       scan_next;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [3:0]       on_mask;
   logic [7:0]       read_v;

   // Effective digit count: zero acts as one, clamp at MAX_DIGITS
   always_comb begin
      if (count_ff == 3'd0) begin
         active = 3'd1;
      end else if (count_ff > 3'(MAX_DIGITS)) begin
         active = 3'(MAX_DIGITS);
      end else begin
         active = count_ff;
      end
   end

   // Remainders from the precomputed quotients
   always_comb begin
      rem_unit    = item.number_value - ({item.quot_ten[10:0], 3'b000}
                    + {2'b00, item.quot_ten, 1'b0});
      rem_ten     = item.quot_ten - ({item.quot_hundred, 3'b000}
                    + {2'b00, item.quot_hundred, 1'b0});
      rem_hundred = item.quot_hundred - ({item.quot_thousand[4:0], 3'b000}
                    + {2'b00, item.quot_thousand, 1'b0});
      digit[0]    = rem_unit[3:0];
      digit[1]    = rem_ten[3:0];
      digit[2]    = rem_hundred[3:0];
      digit[3]    = (item.quot_thousand >= 5'd10) ? 4'(item.quot_thousand - 5'd10)
                                                  : item.quot_thousand[3:0];
   end

   // Scan position, pulled back to digit 0 if the count was lowered
   assign scan_pos  = (3'(pos_ff) >= active) ? '0 : pos_ff;
   assign scan_next = 3'(scan_pos) + 3'd1;
   assign on_mask   = 4'd1 << scan_pos;

   assign rd_addr = (item.kind == KIND_READ) ? item.digit_index[IDX_W-1:0] : scan_pos;
   assign rd_data = store_ff[rd_addr];

   always_comb begin
      store_in = store_ff;
      pos_in   = pos_ff;
      pins_in  = pins_ff;
      latch_in = latch_ff;
      read_v   = 8'h00;
      case (item.kind)
         KIND_SET_RAW: begin
            for (int k = 0; k < MAX_DIGITS; k++) begin
               if (item.digit_index == 3'(k) && 3'(k) < active) begin
                  store_in[k] = inv_ff ? ~item.segment_value : item.segment_value;
               end
            end
         end
         KIND_SET_NUMBER: begin
            for (int k = 0; k < MAX_DIGITS; k++) begin
               if (3'(k) < active) begin
                  store_in[k] = inv_ff ? ~seg_pattern(digit[k]) : seg_pattern(digit[k]);
               end
            end
         end
         KIND_READ: begin
            if (item.digit_index < active) begin
               read_v = inv_ff ? ~rd_data : rd_data;
            end
         end
         KIND_SCAN: begin
            pins_in  = inv_ff ? on_mask : ~on_mask;
            latch_in = rd_data;
            pos_in   = (scan_next >= active) ? '0 : scan_next[IDX_W-1:0];
         end
         default: begin
            read_v = 8'h00;
         end
      endcase
   end

   assign result.read_value   = read_v;
   assign result.digit_enable = pins_in;
   assign result.segment_port = latch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= DIGIT_COUNT_RESET;
         inv_ff   <= 1'b0;
         pos_ff   <= '0;
         pins_ff  <= 4'hF;
         latch_ff <= 8'h00;
         for (int k = 0; k < MAX_DIGITS; k++) begin
            store_ff[k] <= 8'h00;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DIGIT_COUNT:   count_ff <= csr_wdata;
               CSR_INVERTED_MODE: inv_ff   <= csr_wdata[0];
               default:           count_ff <= count_ff;
            endcase
         end
         if (fire) begin
            store_ff <= store_in;
            pos_ff   <= pos_in;
            pins_ff  <= pins_in;
            latch_ff <= latch_in;
         end
      end
   end

endmodule

@@ sv/multiplexed_seven_segment_driver_core.sv @@
// Multiplexed seven-segment driver core. Keeps one segment byte per digit
// (up to MAX_DIGITS, at most four) and handles four kinds of request beat,
// selected by req_tuser: set a raw byte, set a decimal number 0..9999
// (larger numbers wrap modulo 10000), read a byte back, or a scan tick that
// lights the next digit and latches its byte onto the segment port. Every
// request beat returns exactly one response beat carrying the read value
// (zero unless a read hits a digit in use), the digit select pin levels and
// the segment port byte. Throughput is one beat per clock while rsp_tready is
// high. The first register stage holds the beat with its /10, /100, /1000
// reciprocal products, the second applies the remainders, pattern lookup and
// state update and registers the response.
// While a response waits for rsp_tready the request side takes one more beat
// into the input stage, which acts as the skid, and then holds req_tready low.
// Write csr registers only while idle:
// index 0 is digit_count (0 acts as 1, clamped to MAX_DIGITS), index 1 is
// inverted_mode (complemented bytes on store and read, active-high selects).
module multiplexed_seven_segment_driver_core #(
   parameter int MAX_DIGITS = mds_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // digit_index[2:0], segment_value[10:3],
                                    // number_value[24:11], zero pad
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // read_value[7:0], digit_enable[11:8],
                                    // segment_port[19:12], zero pad
   // configuration write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [2:0]  csr_wdata
);
   import mds_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;

   logic       req_beat;
   logic       advance;

   // Quotients are computed from the incoming beat, ahead of the first register
   mds_decimal_split u_split (
      .number_value  (req_tdata[24:11]),
      .quot_ten      (s1_item_in.quot_ten),
      .quot_hundred  (s1_item_in.quot_hundred),
      .quot_thousand (s1_item_in.quot_thousand)
   );

   assign s1_item_in.kind          = kind_type'(req_tuser);
   assign s1_item_in.digit_index   = req_tdata[2:0];
   assign s1_item_in.segment_value = req_tdata[10:3];
   assign s1_item_in.number_value  = req_tdata[24:11];

   // Second stage moves when the response slot is free or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   mds_display_state #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (advance),
      .item      (s1_item_ff),
      .result    (result)
   );

   always_comb begin
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_item_ff <= s1_item_in;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.segment_port,
                        rsp_data_ff.digit_enable, rsp_data_ff.read_value};

endmodule

@@ sv/mds_checker.sv @@
module mds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // Out of reset the block is empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // Digit selects: all off, or exactly one digit lit at either polarity
   a_pins_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones(rsp_tdata[11:8]) == 1
                      || $countones(rsp_tdata[11:8]) == 3
                      || rsp_tdata[11:8] == 4'hF))
      else $error("digit select pattern malformed");

   // Pad bits above the payload stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:20] == 4'h0))
      else $error("response pad bits set");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response beat changed");

endmodule

bind multiplexed_seven_segment_driver_core mds_checker u_mds_checker (.*);
